// ===== rtl/core/iphs_pkg.sv =====
`default_nettype none
package iphs_pkg;
  localparam int BUCKET_BITS = 8;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int SLOT_BITS = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int NUM_SLOTS = (1 << BUCKET_BITS) * SLOTS_PER_BUCKET;
  localparam int IDX_BITS = $clog2(NUM_SLOTS);
  localparam int CNT_BITS = 11;
  localparam logic [31:0] JH_INIT = 32'hdeadbeef;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_TEST = 2'd2;
  localparam logic [1:0] OP_SWEEP = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_COVERED = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_BUCKET_FULL = 3'd5;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd6;
  localparam logic [2:0] ST_EXPIRED = 3'd7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] address;
    logic [5:0] prefix_len;
    logic [31:0] expiry_time;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [CNT_BITS-1:0] element_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // capture request
    logic hash_start;   // start hash of masked key
    logic use_probe;    // key from probe length, else request length
    logic probe_first;  // probe length to 1
    logic probe_next;   // probe length + 1
    logic scan_clear;   // slot counter to 0
    logic scan_next;    // slot counter + 1
    logic rd;           // read slot at scan address
    logic rd_sweep;     // read slot at sweep address
    logic sweep_clear;
    logic sweep_next;
    logic clear;        // clear valid bit at sweep address
    logic remove;       // remove slot held in last read address
    logic insert;       // write new entry at scan address
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic probe_present; // prefix count of probe length nonzero
    logic probe_last;    // probe length is 32
    logic scan_last;
    logic sweep_last;
    logic hit_valid;     // read slot valid
    logic hit_match;     // read slot matches key
    logic hit_stale;
    logic table_full;
    logic len_bad;
  } sts_t;

  function automatic logic [31:0] netmask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len != 6'd0) m = 32'hffffffff << (6'd32 - len);
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/iphs_if.sv =====
`default_nettype none
interface iphs_req_if;
  logic valid;
  logic ready;
  iphs_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface iphs_rsp_if;
  logic valid;
  logic ready;
  iphs_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/iphs_hash.sv =====
`default_nettype none
module iphs_hash (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [31:0] key,
  input  wire logic [31:0] seed,
  output logic done,
  output logic [iphs_pkg::BUCKET_BITS-1:0] bucket
);
  import iphs_pkg::*;
  // one mix step per cycle, seven steps
  logic [31:0] a, b, c, iv;
  logic [2:0] step;
  logic busy;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  assign iv = seed + JH_INIT + 32'd4;
  assign bucket = c[BUCKET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= key + iv;
      b <= iv;
      c <= iv;
    end else if (busy) begin
      case (step)
        3'd0: c <= (c ^ b) - rotl(b, 14);
        3'd1: a <= (a ^ c) - rotl(c, 11);
        3'd2: b <= (b ^ a) - rotl(a, 25);
        3'd3: c <= (c ^ b) - rotl(b, 16);
        3'd4: a <= (a ^ c) - rotl(c, 4);
        3'd5: b <= (b ^ a) - rotl(a, 14);
        default: c <= (c ^ b) - rotl(b, 24);
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/iphs_datapath.sv =====
`default_nettype none
module iphs_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire iphs_pkg::cmd_t cmd,
  input  wire iphs_pkg::req_t req,
  input  wire logic [31:0] seed,
  output iphs_pkg::sts_t sts,
  output logic [iphs_pkg::CNT_BITS-1:0] total
);
  import iphs_pkg::*;

  req_t r;
  logic [5:0] probe;
  logic [31:0] key;
  logic [BUCKET_BITS-1:0] bucket, bucket_q;
  logic hash_done;
  logic [SLOT_BITS-1:0] slot;
  logic [IDX_BITS-1:0] sweep_idx, rd_idx, scan_idx;
  logic mem_vld [NUM_SLOTS];
  logic [31:0] mem_net [NUM_SLOTS];
  logic [5:0] mem_pfx [NUM_SLOTS];
  logic [31:0] mem_exp [NUM_SLOTS];
  logic [31:0] q_net, q_exp;
  logic [5:0] q_pfx;
  logic q_valid;
  logic [CNT_BITS-1:0] pcount [32];
  logic [5:0] klen;
  logic [4:0] rem_p;

  assign klen = cmd.use_probe ? probe : r.prefix_len;
  assign key = r.address & netmask(klen);

  iphs_hash u_hash (
    .clk(clk), .rst(rst), .start(cmd.hash_start), .key(key), .seed(seed),
    .done(hash_done), .bucket(bucket)
  );

  always_ff @(posedge clk) if (hash_done) bucket_q <= bucket;

  if (SLOTS_PER_BUCKET > 1) begin : g_multi
    assign scan_idx = IDX_BITS'({bucket_q, slot[SLOT_BITS-1:0]});
  end else begin : g_single
    assign scan_idx = IDX_BITS'(bucket_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.probe_first) probe <= 6'd1;
    else if (cmd.probe_next) probe <= probe + 6'd1;
    if (cmd.scan_clear) slot <= '0;
    else if (cmd.scan_next) slot <= slot + 1'b1;
    if (rst || cmd.sweep_clear) sweep_idx <= '0;
    else if (cmd.sweep_next) sweep_idx <= sweep_idx + 1'b1;
  end

  // slot memories, registered read, one valid write per cycle
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem_net[scan_idx] <= key;
      mem_pfx[scan_idx] <= r.prefix_len;
      mem_exp[scan_idx] <= r.expiry_time;
    end
    if (cmd.clear) mem_vld[sweep_idx] <= 1'b0;
    else if (cmd.remove) mem_vld[rd_idx] <= 1'b0;
    else if (cmd.insert) mem_vld[scan_idx] <= 1'b1;
    if (cmd.rd || cmd.rd_sweep) begin
      q_net <= mem_net[cmd.rd_sweep ? sweep_idx : scan_idx];
      q_pfx <= mem_pfx[cmd.rd_sweep ? sweep_idx : scan_idx];
      q_exp <= mem_exp[cmd.rd_sweep ? sweep_idx : scan_idx];
      rd_idx <= cmd.rd_sweep ? sweep_idx : scan_idx;
      q_valid <= mem_vld[cmd.rd_sweep ? sweep_idx : scan_idx];
    end
  end

  assign rem_p = 5'(q_pfx - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < 32; i++) pcount[i] <= '0;
    end else if (cmd.remove) begin
      if (total != '0) total <= total - 1'b1;
      if (pcount[rem_p] != '0) pcount[rem_p] <= pcount[rem_p] - 1'b1;
    end else if (cmd.insert) begin
      total <= total + 1'b1;
      pcount[5'(r.prefix_len - 6'd1)] <= pcount[5'(r.prefix_len - 6'd1)] + 1'b1;
    end
  end

  always_comb begin
    sts.hash_done = hash_done;
    sts.probe_present = pcount[5'(probe - 6'd1)] != '0;
    sts.probe_last = probe == 6'd32;
    sts.scan_last = slot == SLOT_BITS'(SLOTS_PER_BUCKET - 1);
    sts.sweep_last = sweep_idx == IDX_BITS'(NUM_SLOTS - 1);
    sts.hit_valid = q_valid;
    sts.hit_match = q_valid && q_net == key && q_pfx == klen;
    sts.hit_stale = q_exp != 32'd0 && q_exp < r.current_time;
    sts.table_full = 32'(total) >= NUM_SLOTS;
    sts.len_bad = r.prefix_len == 6'd0 || r.prefix_len > 6'd32;
  end
endmodule
`default_nettype wire

// ===== rtl/core/iphs_ctrl.sv =====
`default_nettype none
module iphs_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] status,
  output iphs_pkg::cmd_t cmd,
  input  wire iphs_pkg::sts_t sts
);
  import iphs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SW_RD = 4'd1;
  localparam logic [3:0] S_SW_CHK = 4'd2;
  localparam logic [3:0] S_T_LEN = 4'd3;
  localparam logic [3:0] S_T_HASH = 4'd4;
  localparam logic [3:0] S_T_RD = 4'd5;
  localparam logic [3:0] S_T_CHK = 4'd6;
  localparam logic [3:0] S_K_HASH = 4'd7;
  localparam logic [3:0] S_K_RD = 4'd8;
  localparam logic [3:0] S_K_CHK = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;
  localparam logic [3:0] S_K_WAIT = 4'd11;
  localparam logic [3:0] S_CLR = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] op;
  logic [2:0] status_next;
  logic after_sweep, after_sweep_next;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      after_sweep <= 1'b0;
    end else begin
      state <= state_next;
      after_sweep <= after_sweep_next;
    end
    if (in_valid && in_ready) op <= opcode;
    status <= status_next;
  end

  always_comb begin
    state_next = state;
    status_next = status;
    after_sweep_next = after_sweep;
    cmd = '0;
    cmd.use_probe = 1'b1;
    unique case (state)
      S_CLR: begin
        // clearing pass over the valid bits after reset
        cmd.clear = 1'b1;
        cmd.sweep_next = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.sweep_clear = 1'b1;
          cmd.probe_first = 1'b1;
          after_sweep_next = 1'b0;
          unique case (opcode)
            OP_SWEEP: state_next = S_SW_RD;
            OP_DEL: state_next = S_K_HASH;
            default: state_next = S_T_LEN; // add checks fullness there
          endcase
        end
      end
      S_SW_RD: begin
        cmd.rd_sweep = 1'b1;
        state_next = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (sts.hit_valid && sts.hit_stale) cmd.remove = 1'b1;
        cmd.sweep_next = 1'b1;
        if (sts.sweep_last) begin
          if (op == OP_SWEEP) begin
            status_next = ST_DONE;
            state_next = S_OUT;
          end else begin
            after_sweep_next = 1'b1;
            state_next = S_T_LEN;
          end
        end else state_next = S_SW_RD;
      end
      S_T_LEN: begin
        if (op == OP_ADD && !after_sweep && sts.table_full) begin
          state_next = S_SW_RD;
        end else if (op == OP_ADD && after_sweep && sts.table_full) begin
          status_next = ST_TABLE_FULL;
          state_next = S_OUT;
        end else if (sts.probe_present) begin
          cmd.hash_start = 1'b1;
          state_next = S_T_HASH;
        end else if (sts.probe_last) begin
          status_next = ST_NOT_FOUND;
          state_next = (op == OP_ADD) ? S_K_HASH : S_OUT;
        end else cmd.probe_next = 1'b1;
        after_sweep_next = 1'b1;
      end
      S_T_HASH: begin
        cmd.scan_clear = 1'b1;
        if (sts.hash_done) state_next = S_T_RD;
      end
      S_T_RD: begin
        cmd.rd = 1'b1;
        state_next = S_T_CHK;
      end
      S_T_CHK: begin
        if (sts.hit_match) begin
          if (sts.hit_stale) begin
            cmd.remove = 1'b1;
            status_next = ST_EXPIRED;
            state_next = (op == OP_ADD) ? S_K_HASH : S_OUT;
          end else begin
            status_next = (op == OP_ADD) ? ST_COVERED : ST_FOUND;
            state_next = S_OUT;
          end
        end else if (!sts.scan_last) begin
          cmd.scan_next = 1'b1;
          state_next = S_T_RD;
        end else if (sts.probe_last) begin
          status_next = ST_NOT_FOUND;
          state_next = (op == OP_ADD) ? S_K_HASH : S_OUT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_T_LEN;
        end
      end
      S_K_HASH: begin
        cmd.use_probe = 1'b0;
        if (sts.len_bad) begin
          status_next = ST_BAD_PREFIX;
          state_next = S_OUT;
        end else begin
          cmd.hash_start = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next = S_K_WAIT;
        end
      end
      S_K_WAIT: begin
        cmd.use_probe = 1'b0;
        cmd.scan_clear = 1'b1;
        if (sts.hash_done) state_next = S_K_RD;
      end
      S_K_RD: begin
        cmd.use_probe = 1'b0;
        cmd.rd = 1'b1;
        state_next = S_K_CHK;
      end
      S_K_CHK: begin
        cmd.use_probe = 1'b0;
        if (op == OP_DEL && sts.hit_match) begin
          cmd.remove = 1'b1;
          status_next = ST_DONE;
          state_next = S_OUT;
        end else if (op == OP_ADD && !sts.hit_valid) begin
          cmd.insert = 1'b1;
          status_next = ST_DONE;
          state_next = S_OUT;
        end else if (!sts.scan_last) begin
          cmd.scan_next = 1'b1;
          state_next = S_K_RD;
        end else begin
          status_next = (op == OP_ADD) ? ST_BUCKET_FULL : ST_NOT_FOUND;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/ipv4_prefix_hash_set.sv =====
`default_nettype none
// channel   dir  payload
// in_ch     in   opcode, address, prefix_len, expiry_time, current_time
// out_ch    out  status, element_count
// cfg       in   hash_seed (cfg_we, cfg_data)
// one transaction at a time; a sweep reads and then checks each slot in turn (S_SW_RD, S_SW_CHK)
// test walks the prefix lengths, skipping absent ones and hashing and scanning the bucket for present ones
// the 7-step hash unit and the single read port of the slot memory set the pace
// rst clears prefix counts, total and the seed, then a pass over every slot clears
// the valid bits before the first transaction is accepted
// out_ch holds its result until taken; no new transaction is accepted meanwhile
module ipv4_prefix_hash_set (
  input  wire logic clk,
  input  wire logic rst,
  iphs_req_if.sink in_ch,
  iphs_rsp_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [31:0] cfg_data
);
  import iphs_pkg::*;

  logic [31:0] seed;
  cmd_t cmd;
  sts_t sts;
  logic [CNT_BITS-1:0] total;
  logic [2:0] status;

  // hash seed register
  always_ff @(posedge clk) begin
    if (rst) seed <= '0;
    else if (cfg_we) seed <= cfg_data;
  end

  // sequencer
  iphs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.data.opcode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status),
    .cmd(cmd), .sts(sts)
  );

  // slot table, counts and hash
  iphs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_ch.data), .seed(seed),
    .sts(sts), .total(total)
  );

  assign out_ch.data.status = status;
  assign out_ch.data.element_count = total;

  // never insert and remove in one cycle
  a_excl: assert property (@(posedge clk) disable iff (rst) !(cmd.insert && cmd.remove))
    else $error("insert and remove together");
  // no accept while a result is pending
  a_one: assert property (@(posedge clk) disable iff (rst) !(out_ch.valid && in_ch.ready))
    else $error("accept while result pending");
  // count never exceeds table size
  a_cnt: assert property (@(posedge clk) disable iff (rst) 32'(total) <= NUM_SLOTS)
    else $error("count overflow");
endmodule
`default_nettype wire
